FILE: hw/rtl/asc_pkg.sv
// Shared types and constants for the accelerometer step counter.
`timescale 1ns / 1ps

package asc_pkg;

    // Field widths of the sample and result items.
    localparam int AXIS_W  = 13;
    localparam int MAG_W   = 14;
    localparam int STEP_W  = 16;
    localparam int THR_W   = 14;
    localparam int REFR_W  = 8;

    // Stream bus widths.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_TICKS = 1'd1;
    localparam logic [THR_W-1:0]  THR_RESET  = 14'd307;
    localparam logic [REFR_W-1:0] REFR_RESET = 8'd20;

    // Default sizes of the moving average and of the calibration run.
    localparam int WINDOW_DEF      = 10;
    localparam int CAL_SAMPLES_DEF = 100;

    // Sum of three squared 14-bit differences fits in 28 bits.
    localparam int DIFF_W = AXIS_W + 1;
    localparam int SQ_W   = 28;
    localparam int PROD_W = 26;

    // Quotient bits produced by the constant divider.
    localparam int QUOT_W = 14;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // One sample item as it travels from the front to the back.
    typedef struct packed {
        logic                     recal;
        logic signed [AXIS_W-1:0] accel_z;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_x;
    } t_item;

endpackage

FILE: hw/rtl/accel_step_counter_core.sv
// Top level of the accelerometer step counter: input queue front and processing back.
//
//  Channel  Dir  Bus fields (lowest bit first)
//  s_axis   in   tdata: accel_x[12:0], accel_y[25:13], accel_z[38:26]; tuser: func
//  m_axis   out  tdata: steps_total[15:0], average_magnitude[29:16]; tuser: detected, calibrating
//  cfg      in   i_cfg_addr 0 step_threshold, 1 refractory_ticks; data in i_cfg_wdata
//
// A recalibrate item goes straight to the result register, and a calibration sample first adds
// into the calibration sums; the sample that ends calibration adds three offset divisions.
// A measured sample runs the squares through one multiplier, the bit-pair square root, the
// window update, the division by WINDOW through a reciprocal multiplication, and then
// accept, detection and the result register.
// Reset is synchronous and active low; it restores calibration, the window and the detector.
// A two-entry queue takes new samples while the back works or while a result waits to be taken.
`timescale 1ns / 1ps

module accel_step_counter_core
    import asc_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Sample stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // accel_x, accel_y, accel_z, zero pad
    input  logic                  s_axis_tuser,  // func
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // steps_total, average_magnitude, zero pad
    output logic [M_TUSER_W-1:0]  m_axis_tuser   // step_detected, calibrating
);

    logic  w_item_valid;
    logic  w_item_ready;
    t_item w_item;

    // Front: accepts transfers and queues classified items.
    asc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tvalid     (s_axis_tvalid),
        .o_tready     (s_axis_tready),
        .i_tdata      (s_axis_tdata),
        .i_tuser      (s_axis_tuser),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item)
    );

    // Back: runs each item and holds its result until it is taken.
    asc_back #(
        .WINDOW      (WINDOW),
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tuser      (m_axis_tuser)
    );

endmodule

FILE: hw/rtl/asc_front.sv
// Input side: accepts sample transfers, tags recalibrate items and queues them.
`timescale 1ns / 1ps

module asc_front
    import asc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [S_TDATA_W-1:0] i_tdata,
    input  logic                 i_tuser,
    output logic                 o_item_valid,
    input  logic                 i_item_ready,
    output t_item                o_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    t_item              w_in_item;
    logic               w_push;
    logic               w_pop;

    // Unpack the transfer and classify it by its kind bit.
    always_comb begin
        w_in_item.recal   = i_tuser;
        w_in_item.accel_x = $signed(i_tdata[AXIS_W-1:0]);
        w_in_item.accel_y = $signed(i_tdata[2*AXIS_W-1:AXIS_W]);
        w_in_item.accel_z = $signed(i_tdata[3*AXIS_W-1:2*AXIS_W]);
    end

    assign o_tready     = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_q[r_rd_ptr];
    assign w_push       = i_tvalid && o_tready;
    assign w_pop        = o_item_valid && i_item_ready;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_in_item;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/asc_div.sv
// Divider by one of two constant divisors through a reciprocal multiplication.
`timescale 1ns / 1ps

module asc_div
    import asc_pkg::*;
#(
    parameter int DW    = 24,
    parameter int DEN_A = CAL_SAMPLES_DEF,
    parameter int DEN_B = WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_sel,
    input  logic [DW-1:0]     i_num,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    // For every numerator below 2^DW, floor(n / d) equals (n * ceil(2^s / d)) >> s
    // with s = DW + ceil(log2(d)).
    localparam int     SH_A  = DW + $clog2(DEN_A);
    localparam int     SH_B  = DW + $clog2(DEN_B);
    localparam int     REC_W = DW + 2;
    localparam int     PRD_W = DW + REC_W;
    localparam longint ONE   = 1;
    localparam longint REC_A = ((ONE << SH_A) + longint'(DEN_A) - ONE) / longint'(DEN_A);
    localparam longint REC_B = ((ONE << SH_B) + longint'(DEN_B) - ONE) / longint'(DEN_B);
    localparam logic [REC_W-1:0] REC_A_V = REC_W'(REC_A);
    localparam logic [REC_W-1:0] REC_B_V = REC_W'(REC_B);

    logic              r_busy;
    logic              r_done;
    logic              r_sel;
    logic [DW-1:0]     r_num;
    logic [QUOT_W-1:0] r_quot;
    logic [REC_W-1:0]  w_rec;
    logic [PRD_W-1:0]  w_prod;
    logic [QUOT_W-1:0] w_quot;

    // One multiply by the selected reciprocal, then a constant shift.
    assign w_rec  = r_sel ? REC_B_V : REC_A_V;
    assign w_prod = PRD_W'(r_num) * PRD_W'(w_rec);
    assign w_quot = r_sel ? QUOT_W'(w_prod >> SH_B) : QUOT_W'(w_prod >> SH_A);

    assign o_done = r_done;
    assign o_quot = r_quot;

    // Control: the quotient is registered in the cycle after the operand is captured.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // Datapath: operand capture and quotient register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_sel <= i_sel;
        end
        if (r_busy) begin
            r_quot <= w_quot;
        end
    end

endmodule

FILE: hw/rtl/asc_back.sv
// Processing side: calibration, magnitude, moving average, step detection and result register.
`timescale 1ns / 1ps

module asc_back
    import asc_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_item_valid,
    output logic                  o_item_ready,
    input  t_item                 i_item,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [M_TDATA_W-1:0]  o_tdata,
    output logic [M_TUSER_W-1:0]  o_tuser
);

    // Derived widths.
    localparam int POS_W  = $clog2(WINDOW);
    localparam int TOT_W  = MAG_W + $clog2(WINDOW);
    localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W  = AXIS_W + 1 + $clog2(CAL_SAMPLES);
    localparam int BIAS_W = AXIS_W + $clog2(CAL_SAMPLES);
    localparam int DIV_W  = (TOT_W > BIAS_W) ? TOT_W : BIAS_W;
    localparam int BIAS   = 4096 * CAL_SAMPLES + CAL_SAMPLES / 2;
    localparam logic [SQ_W-1:0]  ROOT_BIT0 = SQ_W'(1) << (SQ_W - 2);
    localparam logic [QUOT_W-1:0] OFS_BIAS = QUOT_W'(4096);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CAL  = 4'd1;
    localparam logic [3:0] S_OFS  = 4'd2;
    localparam logic [3:0] S_OFSW = 4'd3;
    localparam logic [3:0] S_SQ   = 4'd4;
    localparam logic [3:0] S_ROOT = 4'd5;
    localparam logic [3:0] S_WIN  = 4'd6;
    localparam logic [3:0] S_AVG  = 4'd7;
    localparam logic [3:0] S_AVGW = 4'd8;
    localparam logic [3:0] S_DET  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    // Axis selector codes.
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    logic [3:0]               r_state;
    t_item                    r_item;
    logic [1:0]               r_axis;
    logic [THR_W-1:0]         r_thr;
    logic [REFR_W-1:0]        r_refr;

    // Calibration state.
    logic signed [AXIS_W-1:0] r_ofs [3];
    logic signed [SUM_W-1:0]  r_sum [3];
    logic [CNT_W-1:0]         r_cal_cnt;
    logic                     r_active;

    // Magnitude datapath.
    logic [PROD_W-1:0]        r_prod;
    logic [SQ_W-1:0]          r_acc;
    logic [SQ_W-1:0]          r_rv;
    logic [SQ_W-1:0]          r_res;
    logic [SQ_W-1:0]          r_bit;

    // Moving average.
    logic [MAG_W-1:0]         r_win [WINDOW];
    logic [MAG_W-1:0]         r_win_rd;
    logic [POS_W-1:0]         r_pos;
    logic                     r_full;
    logic [TOT_W-1:0]         r_total;
    logic [MAG_W-1:0]         r_avg;

    // Detector.
    logic                     r_armed;
    logic [REFR_W-1:0]        r_dead;
    logic [STEP_W-1:0]        r_steps;
    logic                     r_det;

    // Result register.
    logic                     r_out_valid;
    logic [M_TDATA_W-1:0]     r_out_data;
    logic [M_TUSER_W-1:0]     r_out_user;

    logic signed [AXIS_W-1:0] w_ax;
    logic signed [DIFF_W-1:0] w_d;
    logic signed [SQ_W-1:0]   w_sq;
    logic [SQ_W-1:0]          w_trial;
    logic signed [DIV_W:0]    w_biased;
    logic [MAG_W-1:0]         w_old;
    logic [MAG_W-1:0]         w_mag;
    logic                     w_div_start;
    logic [DIV_W-1:0]         w_div_num;
    logic                     w_div_sel;
    logic                     w_div_done;
    logic [QUOT_W-1:0]        w_quot;
    logic                     w_out_free;
    logic [REFR_W-1:0]        n_dead;
    logic [QUOT_W-1:0]        n_ofs_wide;

    // Axis under work in the squaring and offset steps.
    always_comb begin
        case (r_axis)
            AX_X:    w_ax = r_item.accel_x;
            AX_Y:    w_ax = r_item.accel_y;
            AX_Z:    w_ax = r_item.accel_z;
            default: w_ax = r_item.accel_x;
        endcase
    end

    // Offset-corrected axis and its square.
    assign w_d  = DIFF_W'(w_ax) - DIFF_W'(r_ofs[r_axis]);
    assign w_sq = w_d * w_d;

    // One step of the bit-pair square root.
    assign w_trial = r_res + r_bit;
    assign w_mag   = r_res[MAG_W-1:0];

    // Calibration sum moved into the non-negative range for rounding division.
    assign w_biased = (DIV_W + 1)'(r_sum[r_axis]) + (DIV_W + 1)'(BIAS);

    // Oldest window entry reads as zero until the window has wrapped once.
    assign w_old = r_full ? r_win_rd : '0;

    // Shared divider: offsets divide by CAL_SAMPLES, the window average by WINDOW.
    assign w_div_start = (r_state == S_OFS) || (r_state == S_AVG);
    assign w_div_num   = (r_state == S_OFS) ? w_biased[DIV_W-1:0] : DIV_W'(r_total);
    assign w_div_sel   = (r_state == S_AVG);

    asc_div #(
        .DW    (DIV_W),
        .DEN_A (CAL_SAMPLES),
        .DEN_B (WINDOW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sel   (w_div_sel),
        .i_num   (w_div_num),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign n_ofs_wide   = w_quot - OFS_BIAS;
    assign n_dead       = r_dead + 1'b1;
    assign w_out_free   = !r_out_valid || i_tready;
    assign o_item_ready = (r_state == S_IDLE);

    // Window memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WIN) begin
            r_win[r_pos] <= w_mag;
        end
        r_win_rd <= r_win[r_pos];
    end

    // Squaring and square-root datapath.
    always_ff @(posedge i_clk) begin
        r_prod <= w_sq[PROD_W-1:0];
        if (r_state == S_SQ) begin
            if (r_axis == AX_X) begin
                r_acc <= '0;
            end else begin
                r_acc <= r_acc + SQ_W'(r_prod);
            end
            if (r_axis == 2'd3) begin
                r_rv  <= r_acc + SQ_W'(r_prod);
                r_res <= '0;
                r_bit <= ROOT_BIT0;
            end
        end else if (r_state == S_ROOT) begin
            if (r_rv >= w_trial) begin
                r_rv  <= r_rv - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // Latched item.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_item_valid) begin
            r_item <= i_item;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_data <= {(M_TDATA_W - MAG_W - STEP_W)'(0), r_avg, r_steps};
            r_out_user <= {r_active, r_det};
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_refr <= REFR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_STEP_THRESHOLD:   r_thr  <= i_cfg_wdata[THR_W-1:0];
                CFG_REFRACTORY_TICKS: r_refr <= i_cfg_wdata[REFR_W-1:0];
                default:              ;
            endcase
        end
    end

    // Sequencer and block state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AX_X;
            r_ofs       <= '{default: '0};
            r_sum       <= '{default: '0};
            r_cal_cnt   <= '0;
            r_active    <= 1'b1;
            r_pos       <= '0;
            r_full      <= 1'b0;
            r_total     <= '0;
            r_avg       <= '0;
            r_armed     <= 1'b1;
            r_dead      <= '0;
            r_steps     <= '0;
            r_det       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_det  <= 1'b0;
                        r_axis <= AX_X;
                        if (i_item.recal) begin
                            r_steps   <= '0;
                            r_sum     <= '{default: '0};
                            r_cal_cnt <= '0;
                            r_active  <= 1'b1;
                            r_state   <= S_OUT;
                        end else if (r_active) begin
                            r_state <= S_CAL;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_CAL: begin
                    r_sum[0] <= r_sum[0] + SUM_W'(r_item.accel_x);
                    r_sum[1] <= r_sum[1] + SUM_W'(r_item.accel_y);
                    r_sum[2] <= r_sum[2] + SUM_W'(r_item.accel_z);
                    if (r_cal_cnt == CNT_W'(CAL_SAMPLES - 1)) begin
                        r_cal_cnt <= '0;
                        r_state   <= S_OFS;
                    end else begin
                        r_cal_cnt <= r_cal_cnt + 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_OFS: begin
                    r_state <= S_OFSW;
                end
                S_OFSW: begin
                    if (w_div_done) begin
                        r_ofs[r_axis] <= $signed(n_ofs_wide[AXIS_W-1:0]);
                        if (r_axis == AX_Z) begin
                            r_active <= 1'b0;
                            r_state  <= S_OUT;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_OFS;
                        end
                    end
                end
                S_SQ: begin
                    r_axis <= r_axis + 1'b1;
                    if (r_axis == 2'd3) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (r_bit == SQ_W'(1)) begin
                        r_state <= S_WIN;
                    end
                end
                S_WIN: begin
                    r_total <= r_total - TOT_W'(w_old) + TOT_W'(w_mag);
                    if (r_pos == POS_W'(WINDOW - 1)) begin
                        r_pos  <= '0;
                        r_full <= 1'b1;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_state <= S_AVGW;
                end
                S_AVGW: begin
                    if (w_div_done) begin
                        r_avg   <= w_quot[MAG_W-1:0];
                        r_state <= S_DET;
                    end
                end
                S_DET: begin
                    if (r_armed && (r_avg > r_thr)) begin
                        if (r_steps != '1) begin
                            r_steps <= r_steps + 1'b1;
                        end
                        r_armed <= 1'b0;
                        r_dead  <= '0;
                        r_det   <= 1'b1;
                    end else if (!r_armed) begin
                        if (n_dead >= r_refr) begin
                            r_dead  <= '0;
                            r_armed <= 1'b1;
                        end else begin
                            r_dead <= n_dead;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_user;

endmodule
